// ===== rtl/tcw_pkg.sv =====
// Package for the text console writer: sequencer states, item kinds and
// character codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_BLANK,
    S_RD,
    S_RDATA,
    S_OUT
  } tcw_state_t;

  typedef logic [1:0] kind_t;
  typedef logic [7:0] char_t;

  localparam kind_t KIND_PUT   = 2'd0;
  localparam kind_t KIND_CLEAR = 2'd1;
  localparam kind_t KIND_READ  = 2'd2;

  localparam char_t CH_NUL = 8'h00;
  localparam char_t CH_BS  = 8'h08;
  localparam char_t CH_TAB = 8'h09;
  localparam char_t CH_LF  = 8'h0A;
  localparam char_t CH_CR  = 8'h0D;

  localparam int TAB_STEP   = 4;
  localparam int ATTR_RESET = 15;

endpackage

`default_nettype wire

// ===== rtl/text_console_writer_core.sv =====
// Text console writer top level: sequencer, cursor and attribute registers,
// result register. Depends on tcw_pkg, tcw_addr_unit and tcw_ram.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Word
// in       input      in_valid / in_ready  kind, char_code, read_row, read_col
// out      output     out_valid/out_ready  cursor column, cursor row, cell data
// cfg      input      cfg_wr_en            color attribute byte
//
// A printable character, control code, backspace not at column 0, read out
// of range or unused kind goes from S_EXEC straight to S_OUT to load its
// result. An in-range read goes through the registered RAM port by way of
// S_RD and S_RDATA. A backspace at column 0 walks the previous row through
// the single RAM port, one cell per cycle. A clear writes every cell
// through that port. in_ready returns the cycle after the result is
// loaded. After reset the same fill sweep zeroes the screen, with
// in_ready low. A stalled result holds until out_ready takes it; the next
// word waits in S_OUT.

module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_cursor_col_out,
  output logic [4:0]  out_cursor_row_out,
  output logic [15:0] out_cell_data,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  localparam int CW = $clog2(COLS);
  localparam int RW = $clog2(ROWS);
  localparam int AW = $clog2(ROWS*COLS);
  localparam logic [CW:0]   COL_LIM  = (CW+1)'(COLS);
  localparam logic [RW:0]   ROW_LIM  = (RW+1)'(ROWS);
  localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [AW-1:0] CELL_LAST = AW'(ROWS*COLS - 1);
  localparam logic [CW:0]   TAB_W    = (CW+1)'(TAB_STEP);

  tcw_state_t    state_r, state_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [7:0]    color_r, color_nxt;
  logic [AW-1:0] fill_cnt_r, fill_cnt_nxt;
  logic          fill_init_r, fill_init_nxt;
  logic [15:0]   fill_data_r, fill_data_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic          out_valid_r, out_valid_nxt;

  kind_t         kind_r, kind_nxt;
  char_t         char_r, char_nxt;
  logic [4:0]    rd_row_r, rd_row_nxt;
  logic [6:0]    rd_col_r, rd_col_nxt;
  logic [CW-1:0] scan_col_r, scan_col_nxt;
  logic [CW-1:0] chk_col_r, chk_col_nxt;
  logic [15:0]   res_data_r, res_data_nxt;
  logic [6:0]    out_col_r, out_col_nxt;
  logic [4:0]    out_row_r, out_row_nxt;
  logic [15:0]   out_data_r, out_data_nxt;

  // Screen port and the shared address unit feeding it.
  logic          ram_we, ram_re, use_fill_addr;
  logic [15:0]   ram_wdata, ram_rdata;
  logic [AW-1:0] ram_addr, unit_addr;
  logic [RW-1:0] a_row;
  logic [CW-1:0] a_col;

  // Put decode: what a character does to the cursor and the screen.
  logic          put_we, put_scan, put_bs_step;
  logic [CW:0]   put_col_w;
  logic [RW:0]   put_row_w;
  logic [CW-1:0] put_col;
  logic [RW-1:0] put_row;
  logic [15:0]   blank;
  logic          rd_in_range;

  assign blank = {color_r, 8'h00};
  assign rd_in_range = (32'(rd_row_r) < ROWS) && (32'(rd_col_r) < COLS);

  tcw_addr_unit #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_addr (
    .row (a_row),
    .col (a_col),
    .addr(unit_addr)
  );

  assign ram_addr = use_fill_addr ? fill_cnt_r : unit_addr;

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(ROWS*COLS)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Cursor motion for a put word, with column and row wraparound applied
  // afterward. Backspace at column 0 is handed to the row scan instead.
  always_comb begin
    put_we      = 1'b0;
    put_scan    = 1'b0;
    put_bs_step = 1'b0;
    put_col_w   = {1'b0, cur_col_r};
    put_row_w   = {1'b0, cur_row_r};
    case (char_r) inside
      CH_NUL: begin
      end
      CH_LF, CH_CR: begin
        put_col_w = '0;
        put_row_w = put_row_w + (RW+1)'(1);
      end
      CH_TAB: begin
        put_col_w = put_col_w + TAB_W;
      end
      CH_BS: begin
        if (cur_col_r != '0) begin
          put_we      = 1'b1;
          put_bs_step = 1'b1;
          put_col_w   = put_col_w - (CW+1)'(1);
        end else begin
          put_scan = 1'b1;
        end
      end
      default: begin
        put_we    = 1'b1;
        put_col_w = put_col_w + (CW+1)'(1);
      end
    endcase
    if (put_col_w >= COL_LIM) begin
      put_col_w = '0;
      put_row_w = put_row_w + (RW+1)'(1);
    end
    if (put_row_w >= ROW_LIM) begin
      put_col_w = '0;
      put_row_w = '0;
    end
    put_col = put_col_w[CW-1:0];
    put_row = put_row_w[RW-1:0];
  end

  // Sequencer: next state, register updates and screen port control.
  always_comb begin
    state_nxt     = state_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    color_nxt     = color_r;
    fill_cnt_nxt  = fill_cnt_r;
    fill_init_nxt = fill_init_r;
    fill_data_nxt = fill_data_r;
    chk_vld_nxt   = 1'b0;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    char_nxt      = char_r;
    rd_row_nxt    = rd_row_r;
    rd_col_nxt    = rd_col_r;
    scan_col_nxt  = scan_col_r;
    chk_col_nxt   = chk_col_r;
    res_data_nxt  = res_data_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wdata     = blank;
    use_fill_addr = 1'b0;
    a_row         = cur_row_r;
    a_col         = cur_col_r;
    in_ready      = 1'b0;

    if (cfg_wr_en) begin
      color_nxt = cfg_wr_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_FILL: begin
        ram_we        = 1'b1;
        use_fill_addr = 1'b1;
        ram_wdata     = fill_data_r;
        if (fill_cnt_r == CELL_LAST) begin
          state_nxt = fill_init_r ? S_IDLE : S_OUT;
        end else begin
          fill_cnt_nxt = fill_cnt_r + AW'(1);
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          kind_nxt   = in_kind;
          char_nxt   = in_char_code;
          rd_row_nxt = in_read_row;
          rd_col_nxt = in_read_col;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        res_data_nxt = '0;
        unique case (kind_r)
          KIND_PUT: begin
            if (put_scan) begin
              cur_row_nxt  = (cur_row_r == '0) ? ROW_LAST : cur_row_r - RW'(1);
              scan_col_nxt = COL_LAST;
              state_nxt    = S_SCAN;
            end else begin
              ram_we      = put_we;
              ram_wdata   = put_bs_step ? blank : {color_r, char_r};
              a_col       = put_bs_step ? cur_col_r - CW'(1) : cur_col_r;
              cur_col_nxt = put_col;
              cur_row_nxt = put_row;
              state_nxt   = S_OUT;
            end
          end
          KIND_CLEAR: begin
            fill_cnt_nxt  = '0;
            fill_data_nxt = blank;
            fill_init_nxt = 1'b0;
            cur_col_nxt   = '0;
            cur_row_nxt   = '0;
            state_nxt     = S_FILL;
          end
          KIND_READ: begin
            state_nxt = rd_in_range ? S_RD : S_OUT;
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end
      S_SCAN: begin
        // One read issued per cycle; the cell read last cycle is checked.
        ram_re       = 1'b1;
        a_col        = scan_col_r;
        chk_vld_nxt  = 1'b1;
        chk_col_nxt  = scan_col_r;
        scan_col_nxt = scan_col_r - CW'(1);
        if (chk_vld_r) begin
          if (ram_rdata[7:0] != 8'h00) begin
            cur_col_nxt = chk_col_r;
            chk_vld_nxt = 1'b0;
            state_nxt   = S_BLANK;
          end else if (chk_col_r == '0) begin
            cur_col_nxt = '0;
            chk_vld_nxt = 1'b0;
            state_nxt   = S_OUT;
          end
        end
      end
      S_BLANK: begin
        ram_we    = 1'b1;
        ram_wdata = blank;
        state_nxt = S_OUT;
      end
      S_RD: begin
        ram_re    = 1'b1;
        a_row     = RW'(rd_row_r);
        a_col     = CW'(rd_col_r);
        state_nxt = S_RDATA;
      end
      S_RDATA: begin
        res_data_nxt = ram_rdata;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = 7'(cur_col_r);
          out_row_nxt   = 5'(cur_row_r);
          out_data_nxt  = res_data_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      color_r     <= 8'(ATTR_RESET);
      fill_cnt_r  <= '0;
      fill_init_r <= 1'b1;
      fill_data_r <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      color_r     <= color_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      fill_init_r <= fill_init_nxt;
      fill_data_r <= fill_data_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    char_r     <= char_nxt;
    rd_row_r   <= rd_row_nxt;
    rd_col_r   <= rd_col_nxt;
    scan_col_r <= scan_col_nxt;
    chk_col_r  <= chk_col_nxt;
    res_data_r <= res_data_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_cursor_col_out = out_col_r;
  assign out_cursor_row_out = out_row_r;
  assign out_cell_data      = out_data_r;

`ifndef SYNTHESIS
  // The cursor never rests outside the screen.
  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cur_col_r) < COLS) && (32'(cur_row_r) < ROWS))
    else $error("cursor outside the screen");

  // The screen is never written while the block waits for a word.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("screen write while idle");

  // An accepted word keeps the input closed on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input reopened right after accept");
`endif

endmodule

`default_nettype wire

// ===== rtl/tcw_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcw_addr_unit.sv =====
// Shared cell address unit: row * COLS + col for every screen access but the fill sweep.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tcw_addr_unit #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic [$clog2(ROWS)-1:0]      row,
  input  logic [$clog2(COLS)-1:0]      col,
  output logic [$clog2(ROWS*COLS)-1:0] addr
);

  localparam int AW = $clog2(ROWS*COLS);
  localparam logic [AW-1:0] COLS_A = AW'(COLS);

  assign addr = AW'(row) * COLS_A + AW'(col);

endmodule

`default_nettype wire
